// ===== design/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared constants and types of the serial-bus frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

   localparam int FRAME_LEN = 25;
   localparam int NUM_CH    = 16;
   localparam int RAW_W     = 11;
   localparam int CNT_W     = 5;
   localparam int IDX_W     = 4;
   localparam int CHAN_W    = NUM_CH * RAW_W;
   localparam int DVD_W     = 21;
   localparam int QUO_W     = 10;
   localparam int STEP_W    = 5;
   localparam int DIV_STEPS = DVD_W;
   localparam int LAST_DATA = 22;
   localparam int FLAG_POS  = 23;

   localparam logic [RAW_W-1:0] US_LOW  = 11'd1000;
   localparam logic [RAW_W-1:0] US_HIGH = 11'd2000;
   localparam logic [DVD_W-1:0] US_SPAN = 21'd1000;
   localparam logic [RAW_W-1:0] RAW_MASK = 11'h7FF;

   localparam logic [1:0] ST_NONE  = 2'd0;
   localparam logic [1:0] ST_FRAME = 2'd1;
   localparam logic [1:0] ST_ERROR = 2'd2;

   localparam logic [1:0] REG_START = 2'd0;
   localparam logic [1:0] REG_END   = 2'd1;
   localparam logic [1:0] REG_MIN   = 2'd2;
   localparam logic [1:0] REG_MAX   = 2'd3;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ===== design/sfr_div.sv =====
// ----------------------------------------------------------------------------
// sfr_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sfr_div
   import sfr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DVD_W-1:0]   dividend,
   input  logic [RAW_W-1:0]   divisor,
   output div_stat_type       stat,
   output logic [QUO_W-1:0]   quotient
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [RAW_W:0]    rem_ff, rem_in;
   logic [DVD_W-1:0]  quo_ff, quo_in;
   logic [RAW_W-1:0]  dsr_ff, dsr_in;
   logic [RAW_W:0]    shifted;
   logic [RAW_W+1:0]  trial;
   logic              fits;

   assign shifted = {rem_ff[RAW_W-1:0], quo_ff[DVD_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, dsr_ff};
   assign fits    = ~trial[RAW_W+1];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[DVD_W-2:0], fits};
         rem_in  = fits ? trial[RAW_W:0] : shifted;
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff[QUO_W-1:0];

endmodule

// ===== design/sbus_frame_receiver_top.sv =====
// ----------------------------------------------------------------------------
// sbus_frame_receiver_top
// Serial-bus frame receiver: syncs on the header byte, collects 25-byte
// frames and unpacks 16 channels of 11 bits scaled to microseconds.
//
// The req channel carries one received byte per transfer. Every byte that
// does not complete a good frame gives one rsp transfer (status 0, or
// status 2 when the 25th byte fails the header/end check). The 25th byte
// of a good frame gives 16 rsp transfers, one per channel, last set on
// channel 15. A byte is taken only while the receiver is idle; its rsp is
// registered and shown in the cycle after the req transfer, and the byte
// frees the input once that rsp transfer completes. A channel value that
// clamps is set to 1000 or 2000 us, else the shared one-bit-per-cycle
// divider computes it; a full frame holds the block after the 25th byte's
// transfer until its channels are sent. A stalled rsp holds the block, and
// req_ready stays low until the last rsp transfer completes. Reset
// (synchronous) drops sync and restores the register defaults: start byte
// 15, end byte 0, raw range 172..1811. Registers must be written through
// the APB port only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module sbus_frame_receiver_top
   import sfr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_data_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_status,
   output logic [IDX_W-1:0]  rsp_channel_index,
   output logic [RAW_W-1:0]  rsp_channel_raw,
   output logic [RAW_W-1:0]  rsp_channel_us,
   output logic              rsp_digital_a,
   output logic              rsp_digital_b,
   output logic              rsp_lost_flag,
   output logic              rsp_failsafe_flag,
   output logic              rsp_last,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_ONE  = 3'd1;
   localparam logic [2:0] S_CALC = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_CHAN = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic              synced_ff, synced_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [7:0]        head_ff, head_in;
   logic [3:0]        flags_ff, flags_in;
   logic [CHAN_W-1:0] chan_ff, chan_in;
   logic [1:0]        status_ff, status_in;
   logic [IDX_W-1:0]  index_ff, index_in;
   logic [RAW_W-1:0]  us_ff, us_in;
   logic [7:0]        start_ff, end_ff;
   logic [RAW_W-1:0]  min_ff, max_ff;

   logic              req_xfer, rsp_xfer, cfg_write, frame_ok;
   logic [RAW_W-1:0]  raw, raw_diff, span;
   logic [DVD_W-1:0]  product;
   logic              div_start;
   div_stat_type      div_stat;
   logic [QUO_W-1:0]  quotient;

   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite & pready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_ONE) | (state_ff == S_CHAN);
   assign req_xfer  = req_valid & req_ready;
   assign rsp_xfer  = rsp_valid & rsp_ready;

   assign raw      = chan_ff[RAW_W-1:0];
   assign raw_diff = raw - min_ff;
   assign span     = max_ff - min_ff;
   assign product  = {{(DVD_W-RAW_W){1'b0}}, raw_diff} * US_SPAN;
   assign frame_ok = (head_ff == start_ff) & (req_data_byte == end_ff);

   sfr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product),
      .divisor  (span),
      .stat     (div_stat),
      .quotient (quotient)
   );

   always_comb begin
      state_in  = state_ff;
      synced_in = synced_ff;
      count_in  = count_ff;
      head_in   = head_ff;
      flags_in  = flags_ff;
      chan_in   = chan_ff;
      status_in = status_ff;
      index_in  = index_ff;
      us_in     = us_ff;
      div_start = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               status_in = ST_NONE;
               state_in  = S_ONE;
               if (!synced_ff) begin
                  if (req_data_byte == start_ff) begin
                     head_in   = req_data_byte;
                     count_in  = CNT_W'(1);
                     synced_in = 1'b1;
                  end
               end else if (count_ff == CNT_W'(FRAME_LEN - 1)) begin
                  synced_in = 1'b0;
                  count_in  = '0;
                  if (frame_ok) begin
                     index_in = '0;
                     state_in = S_CALC;
                  end else begin
                     status_in = ST_ERROR;
                  end
               end else begin
                  if (count_ff <= CNT_W'(LAST_DATA)) begin
                     chan_in = {req_data_byte, chan_ff[CHAN_W-1:8]};
                  end
                  if (count_ff == CNT_W'(FLAG_POS)) begin
                     flags_in = req_data_byte[3:0];
                  end
                  count_in = count_ff + 1'b1;
               end
            end
         end
         S_ONE: begin
            if (rsp_xfer) begin
               state_in = S_IDLE;
            end
         end
         S_CALC: begin
            status_in = ST_FRAME;
            if (raw <= min_ff) begin
               us_in    = US_LOW;
               state_in = S_CHAN;
            end else if (raw >= max_ff) begin
               us_in    = US_HIGH;
               state_in = S_CHAN;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_stat.done) begin
               us_in    = US_LOW + {{(RAW_W-QUO_W){1'b0}}, quotient};
               state_in = S_CHAN;
            end
         end
         S_CHAN: begin
            if (rsp_xfer) begin
               if (index_ff == IDX_W'(NUM_CH - 1)) begin
                  state_in = S_IDLE;
               end else begin
                  index_in = index_ff + 1'b1;
                  chan_in  = {{RAW_W{1'b0}}, chan_ff[CHAN_W-1:RAW_W]};
                  state_in = S_CALC;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         synced_ff <= 1'b0;
         count_ff  <= '0;
         status_ff <= ST_NONE;
         index_ff  <= '0;
         start_ff  <= 8'd15;
         end_ff    <= 8'd0;
         min_ff    <= 11'd172;
         max_ff    <= 11'd1811;
      end else begin
         state_ff  <= state_in;
         synced_ff <= synced_in;
         count_ff  <= count_in;
         status_ff <= status_in;
         index_ff  <= index_in;
         if (cfg_write) begin
            case (paddr[3:2])
               REG_START: start_ff <= pwdata[7:0];
               REG_END:   end_ff   <= pwdata[7:0];
               REG_MIN:   min_ff   <= pwdata[RAW_W-1:0] & RAW_MASK;
               REG_MAX:   max_ff   <= pwdata[RAW_W-1:0] & RAW_MASK;
               default: begin
               end
            endcase
         end
      end
      head_ff  <= head_in;
      flags_ff <= flags_in;
      chan_ff  <= chan_in;
      us_ff    <= us_in;
   end

   always_comb begin
      case (paddr[3:2])
         REG_START: prdata = {24'd0, start_ff};
         REG_END:   prdata = {24'd0, end_ff};
         REG_MIN:   prdata = {21'd0, min_ff};
         REG_MAX:   prdata = {21'd0, max_ff};
         default:   prdata = '0;
      endcase
   end

   logic frame_rsp;
   assign frame_rsp = (status_ff == ST_FRAME);

   assign rsp_status        = status_ff;
   assign rsp_channel_index = frame_rsp ? index_ff : '0;
   assign rsp_channel_raw   = frame_rsp ? raw : '0;
   assign rsp_channel_us    = frame_rsp ? us_ff : '0;
   assign rsp_digital_a     = frame_rsp & flags_ff[0];
   assign rsp_digital_b     = frame_rsp & flags_ff[1];
   assign rsp_lost_flag     = frame_rsp & flags_ff[2];
   assign rsp_failsafe_flag = frame_rsp & flags_ff[3];
   assign rsp_last          = frame_rsp ? (index_ff == IDX_W'(NUM_CH - 1)) : 1'b1;

endmodule
